// ----- src/skf_pkg.sv -----
// ----------------------------------------------------------------------------
// skf_pkg: shared definitions for the scalar Kalman filter
// Widths, register indices, reset values, datapath operation codes and the
// command structure passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int CFG_WIDTH      = 32;
  localparam int CFG_IDX_WIDTH  = 2;
  localparam int A_WIDTH        = 16;
  localparam int A_FRAC         = 14;
  localparam int GAIN_WIDTH     = 16;
  localparam int MUL_B_WIDTH    = GAIN_WIDTH + 1;
  localparam int DIV_STEPS      = GAIN_WIDTH + 1;
  localparam int DIV_CNT_WIDTH  = $clog2(DIV_STEPS);
  localparam int OP_WIDTH       = 4;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_PROCESS_NOISE     = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MEASUREMENT_NOISE = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_TRANSITION_GAIN   = 2'd2;

  localparam logic [CFG_WIDTH-1:0] PROCESS_NOISE_RST     = 32'd655;
  localparam logic [CFG_WIDTH-1:0] MEASUREMENT_NOISE_RST = 32'd65536;
  localparam logic [A_WIDTH-1:0]   TRANSITION_GAIN_RST   = 16'd16384;

  localparam logic [OP_WIDTH-1:0] OP_IDLE     = 4'd0;
  localparam logic [OP_WIDTH-1:0] OP_LOAD     = 4'd1;
  localparam logic [OP_WIDTH-1:0] OP_MUL_X    = 4'd2;
  localparam logic [OP_WIDTH-1:0] OP_MUL_P    = 4'd3;
  localparam logic [OP_WIDTH-1:0] OP_SAT_T    = 4'd4;
  localparam logic [OP_WIDTH-1:0] OP_MUL_T    = 4'd5;
  localparam logic [OP_WIDTH-1:0] OP_PM       = 4'd6;
  localparam logic [OP_WIDTH-1:0] OP_DEN      = 4'd7;
  localparam logic [OP_WIDTH-1:0] OP_DIV      = 4'd8;
  localparam logic [OP_WIDTH-1:0] OP_GAIN     = 4'd9;
  localparam logic [OP_WIDTH-1:0] OP_MUL_CORR = 4'd10;
  localparam logic [OP_WIDTH-1:0] OP_MUL_PN   = 4'd11;
  localparam logic [OP_WIDTH-1:0] OP_WRITE    = 4'd12;

  typedef struct packed {
    logic [OP_WIDTH-1:0] op;
    logic                div_first;
  } skf_cmd_t;

endpackage

// ----- src/skf_datapath.sv -----
// ----------------------------------------------------------------------------
// skf_datapath: arithmetic and state of the scalar Kalman filter
// Holds the configuration, the filter state and the working registers, one
// shared multiplier and a restoring divider stepped one quotient bit a cycle.
// ----------------------------------------------------------------------------
module skf_datapath #(
  parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  skf_pkg::skf_cmd_t                  cmd_i,
  input  logic                               cfg_we_i,
  input  logic [skf_pkg::CFG_IDX_WIDTH-1:0]  cfg_index_i,
  input  logic [skf_pkg::CFG_WIDTH-1:0]      cfg_data_i,
  input  logic signed [DATA_WIDTH-1:0]       measurement_i,
  output logic signed [DATA_WIDTH-1:0]       estimate_o
);
  import skf_pkg::*;

  localparam int SUM_W  = ((DATA_WIDTH > CFG_WIDTH) ? DATA_WIDTH : CFG_WIDTH) + 1;
  localparam int REM_W  = SUM_W + 1;
  localparam int MULA_W = DATA_WIDTH + 1;
  localparam int PROD_W = MULA_W + MUL_B_WIDTH;
  localparam int SH_W   = PROD_W - A_FRAC;
  localparam int GS_W   = PROD_W - GAIN_WIDTH;
  localparam int SX_W   = DATA_WIDTH + 2;
  localparam logic [DATA_WIDTH-1:0] S_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] S_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic [CFG_WIDTH-1:0]   q_noise_q, r_noise_q;
  logic [A_WIDTH-1:0]     a_gain_q;
  logic [DATA_WIDTH-1:0]  x_q, p_q, z_q, xm_q, t_q, pm_q, xn_q, estimate_q;
  logic [SUM_W-1:0]       den_q;
  logic [REM_W-1:0]       rem_q;
  logic [DIV_STEPS-1:0]   quo_q;
  logic [GAIN_WIDTH-1:0]  k_q;
  logic [DATA_WIDTH:0]    innov_q;
  logic [PROD_W-1:0]      prod_q;

  logic                   a_neg, xm_neg, xm_over, innov_neg, ge, mul_en, xsum_fits;
  logic [A_WIDTH-1:0]     a_mag;
  logic [DATA_WIDTH-1:0]  x_mag, cov14, xm_d, pm_d, xn_d, pn_d;
  logic [DATA_WIDTH:0]    innov_mag, innov_d, corr_mag;
  logic [SH_W-1:0]        sh14;
  logic [GS_W-1:0]        pn_sh;
  logic [SUM_W-1:0]       pm_sum, den_d;
  logic [REM_W-1:0]       trial, rem_d;
  logic [GAIN_WIDTH-1:0]  gain_d;
  logic [SX_W-1:0]        corr_s, xsum;
  logic [MULA_W-1:0]      mul_a;
  logic [MUL_B_WIDTH-1:0] mul_b, gain_comp;
  logic [PROD_W-1:0]      prod_d;

  always_comb begin
    a_neg     = a_gain_q[A_WIDTH-1];
    a_mag     = a_neg ? (~a_gain_q + 1'b1) : a_gain_q;
    x_mag     = x_q[DATA_WIDTH-1] ? (~x_q + 1'b1) : x_q;
    innov_neg = innov_q[DATA_WIDTH];
    innov_mag = innov_neg ? (~innov_q + 1'b1) : innov_q;

    sh14    = prod_q[PROD_W-1:A_FRAC];
    cov14   = (|sh14[SH_W-1:DATA_WIDTH]) ? '1 : sh14[DATA_WIDTH-1:0];
    xm_over = |sh14[SH_W-1:DATA_WIDTH-1];
    xm_neg  = x_q[DATA_WIDTH-1] ^ a_neg;
    if (xm_over) begin
      xm_d = xm_neg ? S_MIN : S_MAX;
    end else begin
      xm_d = xm_neg ? (~sh14[DATA_WIDTH-1:0] + 1'b1) : sh14[DATA_WIDTH-1:0];
    end

    pm_sum = SUM_W'(cov14) + SUM_W'(q_noise_q);
    pm_d   = (|pm_sum[SUM_W-1:DATA_WIDTH]) ? '1 : pm_sum[DATA_WIDTH-1:0];
    den_d  = SUM_W'(pm_q) + SUM_W'(r_noise_q);
    innov_d = {z_q[DATA_WIDTH-1], z_q} - {xm_q[DATA_WIDTH-1], xm_q};

    trial  = cmd_i.div_first ? rem_q : {rem_q[REM_W-2:0], 1'b0};
    ge     = (trial >= REM_W'(den_q));
    rem_d  = ge ? (trial - REM_W'(den_q)) : trial;
    if (den_q == '0) begin
      gain_d = '0;
    end else begin
      gain_d = quo_q[DIV_STEPS-1] ? '1 : quo_q[GAIN_WIDTH-1:0];
    end

    corr_mag  = prod_q[GAIN_WIDTH +: MULA_W];
    corr_s    = innov_neg ? (~SX_W'(corr_mag) + 1'b1) : SX_W'(corr_mag);
    xsum      = {{2{xm_q[DATA_WIDTH-1]}}, xm_q} + corr_s;
    xsum_fits = (&xsum[SX_W-1:DATA_WIDTH-1]) || !(|xsum[SX_W-1:DATA_WIDTH-1]);
    if (xsum_fits) begin
      xn_d = xsum[DATA_WIDTH-1:0];
    end else begin
      xn_d = xsum[SX_W-1] ? S_MIN : S_MAX;
    end

    pn_sh     = prod_q[PROD_W-1:GAIN_WIDTH];
    pn_d      = (|pn_sh[GS_W-1:DATA_WIDTH]) ? '1 : pn_sh[DATA_WIDTH-1:0];
    gain_comp = {1'b1, {GAIN_WIDTH{1'b0}}} - {1'b0, k_q};

    mul_en = 1'b1;
    case (cmd_i.op)
      OP_MUL_X: begin
        mul_a = {1'b0, x_mag};
        mul_b = {1'b0, a_mag};
      end
      OP_MUL_P: begin
        mul_a = {1'b0, p_q};
        mul_b = {1'b0, a_mag};
      end
      OP_MUL_T: begin
        mul_a = {1'b0, t_q};
        mul_b = {1'b0, a_mag};
      end
      OP_MUL_CORR: begin
        mul_a = innov_mag;
        mul_b = {1'b0, k_q};
      end
      OP_MUL_PN: begin
        mul_a = {1'b0, pm_q};
        mul_b = gain_comp;
      end
      default: begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
      end
    endcase
    prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_noise_q <= PROCESS_NOISE_RST;
      r_noise_q <= MEASUREMENT_NOISE_RST;
      a_gain_q  <= TRANSITION_GAIN_RST;
      x_q       <= '0;
      p_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_PROCESS_NOISE:     q_noise_q <= cfg_data_i;
          REG_MEASUREMENT_NOISE: r_noise_q <= cfg_data_i;
          REG_TRANSITION_GAIN:   a_gain_q  <= cfg_data_i[A_WIDTH-1:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_WRITE) begin
        x_q <= xn_q;
        p_q <= pn_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= prod_d;
    end
    case (cmd_i.op)
      OP_LOAD:   z_q  <= measurement_i;
      OP_MUL_P:  xm_q <= xm_d;
      OP_SAT_T:  t_q  <= cov14;
      OP_PM:     pm_q <= pm_d;
      OP_DEN: begin
        den_q   <= den_d;
        rem_q   <= REM_W'(pm_q);
        quo_q   <= '0;
        innov_q <= innov_d;
      end
      OP_DIV: begin
        rem_q <= rem_d;
        quo_q <= {quo_q[DIV_STEPS-2:0], ge};
      end
      OP_GAIN:   k_q  <= gain_d;
      OP_MUL_PN: xn_q <= xn_d;
      OP_WRITE:  estimate_q <= xn_q;
      default: ;
    endcase
  end

  assign estimate_o = estimate_q;

endmodule

// ----- src/skf_ctrl.sv -----
// ----------------------------------------------------------------------------
// skf_ctrl: sequencer of the scalar Kalman filter
// Steps the datapath through prediction, gain division and update for each
// accepted sample, and owns the handshake state of both channels.
// ----------------------------------------------------------------------------
module skf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output skf_pkg::skf_cmd_t cmd_o
);
  import skf_pkg::*;

  localparam int STATE_W = 4;
  localparam logic [STATE_W-1:0] S_IDLE  = 4'd0;
  localparam logic [STATE_W-1:0] S_MUL_X = 4'd1;
  localparam logic [STATE_W-1:0] S_MUL_P = 4'd2;
  localparam logic [STATE_W-1:0] S_SAT_T = 4'd3;
  localparam logic [STATE_W-1:0] S_MUL_T = 4'd4;
  localparam logic [STATE_W-1:0] S_PM    = 4'd5;
  localparam logic [STATE_W-1:0] S_DEN   = 4'd6;
  localparam logic [STATE_W-1:0] S_DIV   = 4'd7;
  localparam logic [STATE_W-1:0] S_GAIN  = 4'd8;
  localparam logic [STATE_W-1:0] S_CORR  = 4'd9;
  localparam logic [STATE_W-1:0] S_PN    = 4'd10;
  localparam logic [STATE_W-1:0] S_WRITE = 4'd11;
  localparam logic [DIV_CNT_WIDTH-1:0] DIV_LAST = DIV_CNT_WIDTH'(DIV_STEPS - 1);

  logic [STATE_W-1:0]       state_q, state_d;
  logic [DIV_CNT_WIDTH-1:0] div_cnt_q, div_cnt_d;
  logic                     out_valid_q, out_valid_d;
  logic                     can_write;

  assign can_write = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d         = state_q;
    div_cnt_d       = div_cnt_q;
    out_valid_d     = out_valid_q && out_stall_i;
    cmd_o.op        = OP_IDLE;
    cmd_o.div_first = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_MUL_X;
        end
      end
      S_MUL_X: begin
        cmd_o.op = OP_MUL_X;
        state_d  = S_MUL_P;
      end
      S_MUL_P: begin
        cmd_o.op = OP_MUL_P;
        state_d  = S_SAT_T;
      end
      S_SAT_T: begin
        cmd_o.op = OP_SAT_T;
        state_d  = S_MUL_T;
      end
      S_MUL_T: begin
        cmd_o.op = OP_MUL_T;
        state_d  = S_PM;
      end
      S_PM: begin
        cmd_o.op = OP_PM;
        state_d  = S_DEN;
      end
      S_DEN: begin
        cmd_o.op  = OP_DEN;
        div_cnt_d = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.op        = OP_DIV;
        cmd_o.div_first = (div_cnt_q == '0);
        div_cnt_d       = div_cnt_q + 1'b1;
        if (div_cnt_q == DIV_LAST) begin
          state_d = S_GAIN;
        end
      end
      S_GAIN: begin
        cmd_o.op = OP_GAIN;
        state_d  = S_CORR;
      end
      S_CORR: begin
        cmd_o.op = OP_MUL_CORR;
        state_d  = S_PN;
      end
      S_PN: begin
        cmd_o.op = OP_MUL_PN;
        state_d  = S_WRITE;
      end
      S_WRITE: begin
        if (can_write) begin
          cmd_o.op    = OP_WRITE;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_MUL_X)
    else $error("Accepted sample did not start the prediction.");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> div_cnt_q <= DIV_LAST)
    else $error("Divider step count out of range.");

  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV && div_cnt_q == DIV_LAST |=> state_q == S_GAIN)
    else $error("Divider did not finish after its last step.");

  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WRITE && can_write |=> out_valid_q && state_q == S_IDLE)
    else $error("Result write did not present a beat.");

endmodule

// ----- src/scalar_kalman_filter.sv -----
// ----------------------------------------------------------------------------
// scalar_kalman_filter: one-dimensional fixed-point Kalman filter
// Each measurement beat runs one predict and update step and yields one
// estimate beat; noise variances and transition gain are configurable.
// ----------------------------------------------------------------------------
// A measurement is accepted only while the filter is idle, and the next one
// is taken only after the result beat of the previous one has been written.
// The restoring divider forms the gain one quotient bit per cycle; the other
// steps use the single shared multiplier, adders and saturation logic. A held
// result beat delays completion of the following sample until it is taken.
// Configuration writes are always accepted and must only be issued while the
// filter is idle.
module scalar_kalman_filter #(
  parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [DATA_WIDTH-1:0]      measurement_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [DATA_WIDTH-1:0]      estimate_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [skf_pkg::CFG_IDX_WIDTH-1:0] cfg_index_i,
  input  logic [skf_pkg::CFG_WIDTH-1:0]     cfg_data_i
);
  import skf_pkg::*;

  skf_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  skf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  skf_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .measurement_i (measurement_i),
    .estimate_o    (estimate_o)
  );

endmodule
